// ----- rtl/bbcd_pkg.sv -----
// Shared types and constants of the buffer cache tag directory.
package bbcd_pkg;

    localparam int SLOTS   = 32;
    localparam int MAX_RUN = 129;
    localparam int SW      = 6;
    localparam int IW      = $clog2(SLOTS);

    localparam logic [SW-1:0] END_CODE  = 6'd63;
    localparam logic [31:0]   EMPTY_TAG = 32'hffff_ffff;

    typedef enum logic [2:0] {
        KIND_HIT   = 3'd0,
        KIND_FILL  = 3'd1,
        KIND_WBACK = 3'd2,
        KIND_ALLOC = 3'd3,
        KIND_DONE  = 3'd4
    } kind_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_WALK_INIT_D,
        OP_WALK_INIT_C,
        OP_WALK_STEP,
        OP_RELINK_HIT,
        OP_EVICT,
        OP_FILL,
        OP_FL_START,
        OP_FL_STEP,
        OP_FL_TAIL_INIT,
        OP_FL_TAIL_STEP,
        OP_FL_SPLICE
    } op_t;

    typedef struct packed {
        op_t  op;
        logic list_is_dirty;
    } bbcd_cmd_t;

    typedef struct packed {
        logic walk_done;
        logic walk_hit;
        logic d_tail_valid;
        logic c_tail_valid;
        logic d_head_valid;
        logic fl_done;
        logic fl_emit;
        logic tail_done;
        logic fill_write;
    } bbcd_stat_t;

endpackage

// ----- rtl/bbcd_datapath.sv -----
// Tag store, link store and list walk datapath of the cache directory.
module bbcd_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bbcd_pkg::bbcd_cmd_t           cmd_in,
    input  logic [7:0]                    req_dev,
    input  logic [31:0]                   req_block,
    input  logic                          req_write,
    output bbcd_pkg::bbcd_stat_t          stat,
    output logic [bbcd_pkg::SW-1:0]       res_slot,
    output logic [7:0]                    res_dev,
    output logic [31:0]                   res_block,
    output logic [5:0]                    res_count
);

    localparam int SLOTS = bbcd_pkg::SLOTS;
    localparam int SW    = bbcd_pkg::SW;
    localparam int IW    = bbcd_pkg::IW;

    logic [31:0]   tag_block_reg [SLOTS];
    logic [7:0]    tag_dev_reg   [SLOTS];
    logic [SW-1:0] link_reg      [SLOTS];
    logic [SLOTS-1:0] dirty_reg;
    logic [SW-1:0] dirty_head_reg, clean_head_reg;

    // walk cursor
    logic [SW-1:0] cur_reg, pre_reg, tail_reg, tpre_reg;
    logic [SW:0]   steps_reg;
    logic          hit_reg;
    logic [SW-1:0] dtail_reg, dtpre_reg;
    // flush scan
    logic [SW:0]   fi_reg;
    logic [SW:0]   rlen_reg;

    function automatic logic [IW-1:0] ix(input logic [SW-1:0] s);
        return s[IW-1:0];
    endfunction

    function automatic logic valid_s(input logic [SW-1:0] s);
        return s < SW'(SLOTS);
    endfunction

    logic cur_ok, cur_match;
    assign cur_ok    = valid_s(cur_reg) && (steps_reg < (SW+1)'(SLOTS));
    assign cur_match = tag_block_reg[ix(cur_reg)] == req_block
                       && tag_dev_reg[ix(cur_reg)] == req_dev;

    // flush run extension test for slot fi+rlen
    logic [SW:0]   fs;
    logic          fs_ok, fs_ext;
    logic [IW-1:0] fst;
    assign fs    = fi_reg + rlen_reg;
    assign fst   = fi_reg[IW-1:0];
    assign fs_ok = fs < (SW+1)'(SLOTS) && int'(rlen_reg) < bbcd_pkg::MAX_RUN;
    assign fs_ext = fs_ok && dirty_reg[fs[IW-1:0]]
                    && tag_block_reg[fs[IW-1:0]] == tag_block_reg[fst] + 32'(rlen_reg)
                    && tag_dev_reg[fs[IW-1:0]] == tag_dev_reg[fst];

    always_comb
    begin
        stat              = '0;
        stat.walk_hit     = hit_reg;
        stat.walk_done    = hit_reg || !cur_ok;
        stat.d_tail_valid = valid_s(dtail_reg);
        stat.c_tail_valid = valid_s(tail_reg);
        stat.d_head_valid = valid_s(dirty_head_reg);
        stat.fl_done      = fi_reg >= (SW+1)'(SLOTS);
        stat.fl_emit      = rlen_reg != '0 && !fs_ext;
        stat.tail_done    = !valid_s(link_reg[ix(cur_reg)])
                            || steps_reg >= (SW+1)'(SLOTS);
        stat.fill_write   = req_write;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < SLOTS; s++)
            begin
                tag_block_reg[s] <= bbcd_pkg::EMPTY_TAG;
                tag_dev_reg[s]   <= '0;
                link_reg[s]      <= (s == 0) ? bbcd_pkg::END_CODE : SW'(s - 1);
            end
            dirty_reg      <= '0;
            dirty_head_reg <= bbcd_pkg::END_CODE;
            clean_head_reg <= SW'(SLOTS - 1);
            cur_reg   <= bbcd_pkg::END_CODE;
            pre_reg   <= bbcd_pkg::END_CODE;
            tail_reg  <= bbcd_pkg::END_CODE;
            tpre_reg  <= bbcd_pkg::END_CODE;
            dtail_reg <= bbcd_pkg::END_CODE;
            dtpre_reg <= bbcd_pkg::END_CODE;
            steps_reg <= '0;
            hit_reg   <= 1'b0;
            fi_reg    <= '0;
            rlen_reg  <= '0;
            res_slot  <= '0;
            res_dev   <= '0;
            res_block <= '0;
            res_count <= '0;
        end
        else
        begin
            case (cmd_in.op)
                bbcd_pkg::OP_WALK_INIT_D,
                bbcd_pkg::OP_WALK_INIT_C:
                begin
                    if (cmd_in.op == bbcd_pkg::OP_WALK_INIT_C)
                    begin
                        // keep the dirty list's tail as fallback victim
                        dtail_reg <= tail_reg;
                        dtpre_reg <= tpre_reg;
                        cur_reg   <= clean_head_reg;
                    end
                    else
                        cur_reg <= dirty_head_reg;
                    pre_reg   <= bbcd_pkg::END_CODE;
                    tail_reg  <= bbcd_pkg::END_CODE;
                    tpre_reg  <= bbcd_pkg::END_CODE;
                    steps_reg <= '0;
                    hit_reg   <= 1'b0;
                end
                bbcd_pkg::OP_WALK_STEP:
                begin
                    if (cur_ok && !hit_reg)
                    begin
                        if (cur_match)
                            hit_reg <= 1'b1;
                        else
                        begin
                            tpre_reg  <= pre_reg;
                            tail_reg  <= cur_reg;
                            pre_reg   <= cur_reg;
                            cur_reg   <= link_reg[ix(cur_reg)];
                            steps_reg <= steps_reg + 1'b1;
                        end
                    end
                end
                bbcd_pkg::OP_RELINK_HIT:
                begin
                    res_slot <= cur_reg;
                    if (cmd_in.list_is_dirty)
                    begin
                        if (valid_s(pre_reg))
                        begin
                            link_reg[ix(pre_reg)] <= link_reg[ix(cur_reg)];
                            link_reg[ix(cur_reg)] <= dirty_head_reg;
                            dirty_head_reg        <= cur_reg;
                        end
                    end
                    else if (req_write)
                    begin
                        if (valid_s(pre_reg))
                            link_reg[ix(pre_reg)] <= link_reg[ix(cur_reg)];
                        else
                            clean_head_reg <= link_reg[ix(cur_reg)];
                        dirty_reg[ix(cur_reg)] <= 1'b1;
                        link_reg[ix(cur_reg)]  <= dirty_head_reg;
                        dirty_head_reg         <= cur_reg;
                    end
                    else if (valid_s(pre_reg))
                    begin
                        link_reg[ix(pre_reg)] <= link_reg[ix(cur_reg)];
                        link_reg[ix(cur_reg)] <= clean_head_reg;
                        clean_head_reg        <= cur_reg;
                    end
                end
                bbcd_pkg::OP_EVICT:
                begin
                    // unlink victim; cur becomes victim
                    if (valid_s(tail_reg))
                    begin
                        cur_reg <= tail_reg;
                        if (valid_s(tpre_reg))
                            link_reg[ix(tpre_reg)] <= link_reg[ix(tail_reg)];
                        else
                            clean_head_reg <= link_reg[ix(tail_reg)];
                    end
                    else
                    begin
                        cur_reg   <= dtail_reg;
                        res_slot  <= dtail_reg;
                        res_dev   <= tag_dev_reg[ix(dtail_reg)];
                        res_block <= tag_block_reg[ix(dtail_reg)];
                        res_count <= 6'd1;
                        if (valid_s(dtpre_reg))
                            link_reg[ix(dtpre_reg)] <= link_reg[ix(dtail_reg)];
                        else
                            dirty_head_reg <= link_reg[ix(dtail_reg)];
                    end
                end
                bbcd_pkg::OP_FILL:
                begin
                    tag_block_reg[ix(cur_reg)] <= req_block;
                    tag_dev_reg[ix(cur_reg)]   <= req_dev;
                    dirty_reg[ix(cur_reg)]     <= req_write;
                    res_slot  <= cur_reg;
                    res_dev   <= req_dev;
                    res_block <= req_block;
                    res_count <= req_write ? 6'd0 : 6'd1;
                    if (req_write)
                    begin
                        link_reg[ix(cur_reg)] <= dirty_head_reg;
                        dirty_head_reg        <= cur_reg;
                    end
                    else
                    begin
                        link_reg[ix(cur_reg)] <= clean_head_reg;
                        clean_head_reg        <= cur_reg;
                    end
                end
                bbcd_pkg::OP_FL_START:
                begin
                    fi_reg   <= '0;
                    rlen_reg <= '0;
                end
                bbcd_pkg::OP_FL_STEP:
                begin
                    if (rlen_reg == '0)
                    begin
                        if (dirty_reg[fst])
                        begin
                            dirty_reg[fst] <= 1'b0;
                            rlen_reg       <= (SW+1)'(1);
                        end
                        else
                            fi_reg <= fi_reg + 1'b1;
                    end
                    else if (fs_ext)
                    begin
                        dirty_reg[fs[IW-1:0]] <= 1'b0;
                        rlen_reg              <= rlen_reg + 1'b1;
                    end
                    else
                    begin
                        // close the run and present it
                        res_slot  <= SW'(fi_reg);
                        res_dev   <= tag_dev_reg[fst];
                        res_block <= tag_block_reg[fst];
                        res_count <= rlen_reg[5:0];
                        fi_reg    <= fs;
                        rlen_reg  <= '0;
                    end
                end
                bbcd_pkg::OP_FL_TAIL_INIT:
                begin
                    cur_reg   <= dirty_head_reg;
                    steps_reg <= '0;
                end
                bbcd_pkg::OP_FL_TAIL_STEP:
                begin
                    cur_reg   <= link_reg[ix(cur_reg)];
                    steps_reg <= steps_reg + 1'b1;
                end
                bbcd_pkg::OP_FL_SPLICE:
                begin
                    link_reg[ix(cur_reg)] <= clean_head_reg;
                    clean_head_reg        <= dirty_head_reg;
                    dirty_head_reg        <= bbcd_pkg::END_CODE;
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

// ----- rtl/bbcd_ctrl.sv -----
// Sequencer for lookups, evictions and flushes of the cache directory.
module bbcd_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 in_cmd,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [2:0]           out_kind,
    output logic                 out_last,
    output logic                 out_zero,
    output bbcd_pkg::bbcd_cmd_t  cmd_out,
    input  bbcd_pkg::bbcd_stat_t stat
);

    typedef enum logic [3:0] {
        S_IDLE, S_DWALK, S_CINIT, S_CWALK, S_HIT, S_EVICT, S_FILL,
        S_FSCAN, S_TINIT, S_TSTEP, S_SPLICE, S_DONE, S_OUT
    } state_t;

    state_t state_reg, ret_reg;
    logic   out_valid_reg, out_last_reg, out_zero_reg;
    logic [2:0] out_kind_reg;
    logic   list_dirty_reg;

    assign in_stall  = state_reg != S_IDLE;
    assign out_valid = out_valid_reg;
    assign out_kind  = out_kind_reg;
    assign out_last  = out_last_reg;
    assign out_zero  = out_zero_reg;

    always_comb
    begin
        cmd_out = '{op: bbcd_pkg::OP_NONE, list_is_dirty: list_dirty_reg};
        case (state_reg)
            S_IDLE:
                if (in_valid)
                    cmd_out.op = in_cmd ? bbcd_pkg::OP_FL_START : bbcd_pkg::OP_WALK_INIT_D;
            S_DWALK, S_CWALK:
                if (!stat.walk_done) cmd_out.op = bbcd_pkg::OP_WALK_STEP;
            S_CINIT:  cmd_out.op = bbcd_pkg::OP_WALK_INIT_C;
            S_HIT:    cmd_out.op = bbcd_pkg::OP_RELINK_HIT;
            S_EVICT:  cmd_out.op = bbcd_pkg::OP_EVICT;
            S_FILL:   cmd_out.op = bbcd_pkg::OP_FILL;
            S_FSCAN:
                if (!stat.fl_done) cmd_out.op = bbcd_pkg::OP_FL_STEP;
            S_TINIT:  cmd_out.op = bbcd_pkg::OP_FL_TAIL_INIT;
            S_TSTEP:
                cmd_out.op = stat.tail_done ? bbcd_pkg::OP_FL_SPLICE
                                            : bbcd_pkg::OP_FL_TAIL_STEP;
            default:  cmd_out.op = bbcd_pkg::OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            ret_reg        <= S_IDLE;
            out_valid_reg  <= 1'b0;
            out_last_reg   <= 1'b0;
            out_zero_reg   <= 1'b0;
            out_kind_reg   <= bbcd_pkg::KIND_HIT;
            list_dirty_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                    if (in_valid)
                        state_reg <= in_cmd ? S_FSCAN : S_DWALK;
                S_DWALK:
                    if (stat.walk_done)
                    begin
                        if (stat.walk_hit)
                        begin
                            list_dirty_reg <= 1'b1;
                            state_reg      <= S_HIT;
                        end
                        else
                            state_reg <= S_CINIT;
                    end
                S_CINIT:
                    state_reg <= S_CWALK;
                S_CWALK:
                    if (stat.walk_done)
                    begin
                        if (stat.walk_hit)
                        begin
                            list_dirty_reg <= 1'b0;
                            state_reg      <= S_HIT;
                        end
                        else if (stat.c_tail_valid)
                            state_reg <= S_EVICT;
                        else if (stat.d_tail_valid)
                            state_reg <= S_EVICT;
                        else
                            state_reg <= S_IDLE;
                    end
                S_HIT:
                begin
                    out_kind_reg  <= bbcd_pkg::KIND_HIT;
                    out_zero_reg  <= 1'b1;
                    out_last_reg  <= 1'b1;
                    out_valid_reg <= 1'b1;
                    ret_reg       <= S_IDLE;
                    state_reg     <= S_OUT;
                end
                S_EVICT:
                    if (stat.c_tail_valid)
                        state_reg <= S_FILL;
                    else
                    begin
                        out_kind_reg  <= bbcd_pkg::KIND_WBACK;
                        out_zero_reg  <= 1'b0;
                        out_last_reg  <= 1'b0;
                        out_valid_reg <= 1'b1;
                        ret_reg       <= S_FILL;
                        state_reg     <= S_OUT;
                    end
                S_FILL:
                begin
                    out_kind_reg  <= stat.fill_write ? bbcd_pkg::KIND_ALLOC
                                                     : bbcd_pkg::KIND_FILL;
                    out_zero_reg  <= 1'b0;
                    out_last_reg  <= 1'b1;
                    out_valid_reg <= 1'b1;
                    ret_reg       <= S_IDLE;
                    state_reg     <= S_OUT;
                end
                S_FSCAN:
                    if (stat.fl_done)
                        state_reg <= stat.d_head_valid ? S_TINIT : S_DONE;
                    else if (stat.fl_emit)
                    begin
                        out_kind_reg  <= bbcd_pkg::KIND_WBACK;
                        out_zero_reg  <= 1'b0;
                        out_last_reg  <= 1'b0;
                        out_valid_reg <= 1'b1;
                        ret_reg       <= S_FSCAN;
                        state_reg     <= S_OUT;
                    end
                S_TINIT:
                    state_reg <= S_TSTEP;
                S_TSTEP:
                    if (stat.tail_done)
                        state_reg <= S_DONE;
                S_DONE:
                begin
                    out_kind_reg  <= bbcd_pkg::KIND_DONE;
                    out_zero_reg  <= 1'b1;
                    out_last_reg  <= 1'b1;
                    out_valid_reg <= 1'b1;
                    ret_reg       <= S_IDLE;
                    state_reg     <= S_OUT;
                end
                S_OUT:
                    if (!out_stall)
                    begin
                        out_valid_reg <= 1'b0;
                        state_reg     <= ret_reg;
                    end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- rtl/block_buffer_cache_directory_core.sv -----
// Top level of the write-back buffer cache tag directory.
//   channel  direction  handshake            payload
//   in       in         in_valid / in_stall  cmd, dev, block, is_write
//   out      out        out_valid/out_stall  kind, slot, out_dev, out_block, count, last
// One item at a time; in_stall stays high until its last beat is taken.
// An access walks the dirty then clean list, one link per cycle. A flush
// scans the slots for runs of dirty, adjacent blocks and writes each run back,
// then walks the dirty list once to splice it onto the clean list.
// Reset is asynchronous; all lists take their reset order at once.
// Each result beat holds in its register while out_stall is high.
module block_buffer_cache_directory_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        cmd,
    input  logic [7:0]  dev,
    input  logic [31:0] block,
    input  logic        is_write,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  kind,
    output logic [5:0]  slot,
    output logic [7:0]  out_dev,
    output logic [31:0] out_block,
    output logic [5:0]  count,
    output logic        last
);

    bbcd_pkg::bbcd_cmd_t  dp_cmd;
    bbcd_pkg::bbcd_stat_t dp_stat;
    logic [7:0]  req_dev_reg;
    logic [31:0] req_block_reg;
    logic        req_write_reg;
    logic        out_zero;
    logic [5:0]  r_slot, r_count;
    logic [7:0]  r_dev;
    logic [31:0] r_block;

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            req_dev_reg   <= dev;
            req_block_reg <= block;
            req_write_reg <= is_write;
        end
    end

    bbcd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_cmd    (cmd),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_kind  (kind),
        .out_last  (last),
        .out_zero  (out_zero),
        .cmd_out   (dp_cmd),
        .stat      (dp_stat)
    );

    bbcd_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_in    (dp_cmd),
        .req_dev   (req_dev_reg),
        .req_block (req_block_reg),
        .req_write (req_write_reg),
        .stat      (dp_stat),
        .res_slot  (r_slot),
        .res_dev   (r_dev),
        .res_block (r_block),
        .res_count (r_count)
    );

    assign slot      = (kind == bbcd_pkg::KIND_DONE) ? 6'd0 : r_slot;
    assign out_dev   = out_zero ? 8'd0 : r_dev;
    assign out_block = out_zero ? 32'd0 : r_block;
    assign count     = out_zero ? 6'd0 : r_count;

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall) else $error("result beat while idle");
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == bbcd_pkg::KIND_DONE) |-> last)
        else $error("flush done without last");
    a_wb_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == bbcd_pkg::KIND_WBACK) |-> (count != 6'd0 && !last))
        else $error("bad write-back beat");

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the buffer cache tag directory core.
module tb_top;

    typedef struct {
        bbcd_pkg::kind_t kind;
        logic [5:0]  slot;
        logic [7:0]  dev;
        logic [31:0] blk;
        logic [5:0]  cnt;
        logic        last;
    } beat_t;

    typedef struct {
        logic        cmd;
        logic [7:0]  dev;
        logic [31:0] blk;
        logic        wr;
        bit          typed;
        bbcd_pkg::kind_t t_kind;
        logic [5:0]  t_slot;
        logic [5:0]  t_cnt;
    } item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        cmd = 1'b0;
    logic [7:0]  dev = '0;
    logic [31:0] block = '0;
    logic        is_write = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  kind;
    logic [5:0]  slot;
    logic [7:0]  out_dev;
    logic [31:0] out_block;
    logic [5:0]  count;
    logic        last;

    block_buffer_cache_directory_core i_dut (.*);

    always #6 clk = ~clk;

    // directory shadow
    logic [31:0] sh_blk [bbcd_pkg::SLOTS];
    logic [7:0]  sh_dev [bbcd_pkg::SLOTS];
    bit          sh_dirty [bbcd_pkg::SLOTS];
    logic [5:0]  sh_next [bbcd_pkg::SLOTS];
    logic [5:0]  dirty_hd, clean_hd;

    beat_t  pending_beats[$];
    item_t  items[$];
    item_t  typed_q[$];
    int     fails = 0;
    bit     quiet = 0;

    function automatic void shadow_reset();
        for (int s = 0; s < bbcd_pkg::SLOTS; s++) begin
            sh_blk[s] = bbcd_pkg::EMPTY_TAG;
            sh_dev[s] = '0;
            sh_dirty[s] = 0;
            sh_next[s] = (s == 0) ? bbcd_pkg::END_CODE : 6'(s - 1);
        end
        dirty_hd = bbcd_pkg::END_CODE;
        clean_hd = 6'(bbcd_pkg::SLOTS - 1);
    endfunction

    function automatic bit find_tag(input logic [5:0] hd, input logic [7:0] d,
                                    input logic [31:0] b, output logic [5:0] hit,
                                    output logic [5:0] hitpre, output logic [5:0] tl,
                                    output logic [5:0] tlpre);
        logic [5:0] p, i;
        int steps;
        p = bbcd_pkg::END_CODE; i = hd; steps = 0;
        hit = bbcd_pkg::END_CODE; hitpre = bbcd_pkg::END_CODE;
        tl = bbcd_pkg::END_CODE; tlpre = bbcd_pkg::END_CODE;
        while (i < bbcd_pkg::SLOTS && steps < bbcd_pkg::SLOTS) begin
            if (sh_blk[i] == b && sh_dev[i] == d) begin
                hit = i;
                hitpre = p;
                return 1;
            end
            tlpre = p;
            tl = i;
            p = i;
            i = sh_next[i];
            steps++;
        end
        return 0;
    endfunction

    function automatic void unlink(bit on_dirty, logic [5:0] s, logic [5:0] pre);
        if (pre < bbcd_pkg::SLOTS) sh_next[pre] = sh_next[s];
        else if (on_dirty) dirty_hd = sh_next[s];
        else clean_hd = sh_next[s];
    endfunction

    function automatic void push_front(bit on_dirty, logic [5:0] s);
        if (on_dirty) begin
            sh_next[s] = dirty_hd;
            dirty_hd = s;
        end else begin
            sh_next[s] = clean_hd;
            clean_hd = s;
        end
    endfunction

    function automatic void add_beat(bbcd_pkg::kind_t k, logic [5:0] s, logic [7:0] d,
                                     logic [31:0] b, logic [5:0] c, logic l);
        beat_t r;
        r.kind = k; r.slot = s; r.dev = d; r.blk = b; r.cnt = c; r.last = l;
        pending_beats.push_back(r);
    endfunction

    function automatic void predict_flush();
        int i, j;
        logic [5:0] t;
        int steps;
        i = 0;
        while (i < bbcd_pkg::SLOTS) begin
            if (!sh_dirty[i]) begin
                i++;
                continue;
            end
            sh_dirty[i] = 0;
            for (j = 1; i + j < bbcd_pkg::SLOTS && j < bbcd_pkg::MAX_RUN; j++) begin
                if (!sh_dirty[i+j] || sh_blk[i+j] != sh_blk[i] + 32'(j) ||
                    sh_dev[i+j] != sh_dev[i])
                    break;
                sh_dirty[i+j] = 0;
            end
            add_beat(bbcd_pkg::KIND_WBACK, 6'(i), sh_dev[i], sh_blk[i], 6'(j), 1'b0);
            i += j;
        end
        if (dirty_hd < bbcd_pkg::SLOTS) begin
            t = dirty_hd;
            steps = 0;
            while (sh_next[t] < bbcd_pkg::SLOTS && steps < bbcd_pkg::SLOTS) begin
                t = sh_next[t];
                steps++;
            end
            sh_next[t] = clean_hd;
            clean_hd = dirty_hd;
            dirty_hd = bbcd_pkg::END_CODE;
        end
        add_beat(bbcd_pkg::KIND_DONE, '0, '0, '0, '0, 1'b1);
    endfunction

    function automatic void predict_access(logic [7:0] d, logic [31:0] b, logic wr);
        logic [5:0] hit, hitpre, tl, tlpre, v, vpre;
        if (find_tag(dirty_hd, d, b, hit, hitpre, tl, tlpre)) begin
            if (hitpre < bbcd_pkg::SLOTS) begin
                unlink(1'b1, hit, hitpre);
                push_front(1'b1, hit);
            end
            add_beat(bbcd_pkg::KIND_HIT, hit, '0, '0, '0, 1'b1);
            return;
        end
        v = tl;
        vpre = tlpre;
        if (find_tag(clean_hd, d, b, hit, hitpre, tl, tlpre)) begin
            if (wr) begin
                unlink(1'b0, hit, hitpre);
                sh_dirty[hit] = 1;
                push_front(1'b1, hit);
            end else if (hitpre < bbcd_pkg::SLOTS) begin
                unlink(1'b0, hit, hitpre);
                push_front(1'b0, hit);
            end
            add_beat(bbcd_pkg::KIND_HIT, hit, '0, '0, '0, 1'b1);
            return;
        end
        if (tl < bbcd_pkg::SLOTS) begin
            v = tl;
            unlink(1'b0, v, tlpre);
        end else if (v < bbcd_pkg::SLOTS) begin
            add_beat(bbcd_pkg::KIND_WBACK, v, sh_dev[v], sh_blk[v], 6'd1, 1'b0);
            unlink(1'b1, v, vpre);
        end else begin
            return;
        end
        sh_blk[v] = b;
        sh_dev[v] = d;
        sh_dirty[v] = wr;
        push_front(wr, v);
        if (wr) add_beat(bbcd_pkg::KIND_ALLOC, v, d, b, 6'd0, 1'b1);
        else add_beat(bbcd_pkg::KIND_FILL, v, d, b, 6'd1, 1'b1);
    endfunction

    function automatic item_t mk(logic c, logic [7:0] d, logic [31:0] b, logic w);
        item_t it;
        it = '{cmd: c, dev: d, blk: b, wr: w, typed: 0, t_kind: bbcd_pkg::KIND_HIT,
               t_slot: '0, t_cnt: '0};
        return it;
    endfunction

    function automatic item_t mk_typed(logic c, logic [7:0] d, logic [31:0] b, logic w,
                                       bbcd_pkg::kind_t k, logic [5:0] s, logic [5:0] n);
        item_t it;
        it = mk(c, d, b, w);
        it.typed = 1; it.t_kind = k; it.t_slot = s; it.t_cnt = n;
        return it;
    endfunction

    // accept and check at the rising edge
    always @(posedge clk) begin
        beat_t e;
        int n0;
        if (rst_n && in_valid && !in_stall) begin
            item_t it;
            it = typed_q.pop_front();
            n0 = pending_beats.size();
            if (it.cmd) predict_flush();
            else predict_access(it.dev, it.blk, it.wr);
            if (it.typed) begin
                if (pending_beats.size() == n0) begin
                    $error("table row: kind expected %0d, no beat predicted", it.t_kind);
                    fails++;
                end else begin
                    if (pending_beats[n0].kind != it.t_kind) begin
                        $error("table row: kind exp %0d got %0d",
                               it.t_kind, pending_beats[n0].kind);
                        fails++;
                    end
                    if (pending_beats[n0].slot != it.t_slot) begin
                        $error("table row: slot exp %0d got %0d",
                               it.t_slot, pending_beats[n0].slot);
                        fails++;
                    end
                    if (pending_beats[n0].cnt != it.t_cnt) begin
                        $error("table row: count exp %0d got %0d",
                               it.t_cnt, pending_beats[n0].cnt);
                        fails++;
                    end
                end
            end
        end
        if (rst_n && out_valid && !out_stall) begin
            if (pending_beats.size() == 0) begin
                $error("unexpected beat kind %0d slot %0d", kind, slot);
                fails++;
            end else begin
                e = pending_beats.pop_front();
                if (kind !== e.kind) begin
                    $error("kind exp %0d got %0d", e.kind, kind); fails++;
                end
                if (slot !== e.slot) begin
                    $error("slot exp %0d got %0d", e.slot, slot); fails++;
                end
                if (out_dev !== e.dev) begin
                    $error("out_dev exp %0d got %0d", e.dev, out_dev); fails++;
                end
                if (out_block !== e.blk) begin
                    $error("out_block exp %h got %h", e.blk, out_block); fails++;
                end
                if (count !== e.cnt) begin
                    $error("count exp %0d got %0d", e.cnt, count); fails++;
                end
                if (last !== e.last) begin
                    $error("last exp %0d got %0d", e.last, last); fails++;
                end
            end
        end
    end

    // receiver stalls in bursts
    always @(negedge clk) begin
        int burst;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            burst = $urandom_range(1, 12);
            out_stall <= 1'b1;
            repeat (burst) @(negedge clk);
            out_stall <= 1'b0;
        end
    end

    initial begin
        #20000000;
        $display("tb_top NOT OK");
        $finish;
    end

    initial begin
        item_t it;
        logic [7:0]  pool [4];
        logic [31:0] base;
        int n, gap, blen;

        shadow_reset();
        // after reset every slot is empty, so the empty tag hits the clean head
        items.push_back(mk_typed(1'b0, 8'd0, bbcd_pkg::EMPTY_TAG, 1'b0,
                                 bbcd_pkg::KIND_HIT, 6'd31, 6'd0));
        items.push_back(mk_typed(1'b1, 8'd0, 32'd0, 1'b0,
                                 bbcd_pkg::KIND_DONE, 6'd0, 6'd0));
        items.push_back(mk_typed(1'b0, 8'd255, 32'hffff_fffe, 1'b1,
                                 bbcd_pkg::KIND_ALLOC, 6'd0, 6'd0));
        items.push_back(mk_typed(1'b0, 8'd255, 32'h0000_0000, 1'b1,
                                 bbcd_pkg::KIND_ALLOC, 6'd1, 6'd0));
        items.push_back(mk_typed(1'b0, 8'd0, 32'h0000_0000, 1'b0,
                                 bbcd_pkg::KIND_FILL, 6'd2, 6'd1));
        items.push_back(mk(1'b0, 8'd255, 32'hffff_fffe, 1'b0));
        items.push_back(mk(1'b0, 8'd0, 32'h0000_0000, 1'b1));
        items.push_back(mk(1'b0, 8'd0, 32'h0000_0001, 1'b1));
        items.push_back(mk(1'b1, 8'h5a, 32'h1234_5678, 1'b1));
        items.push_back(mk(1'b0, 8'd0, bbcd_pkg::EMPTY_TAG, 1'b1));
        items.push_back(mk(1'b0, 8'h80, 32'h8000_0000, 1'b0));
        items.push_back(mk(1'b0, 8'h01, 32'h7fff_ffff, 1'b1));
        // overflow the clean list with writes so dirty tails get evicted
        for (int k = 0; k < 36; k++) items.push_back(mk(1'b0, 8'd7, 32'(100 + k), 1'b1));
        items.push_back(mk(1'b1, 8'd0, 32'd0, 1'b0));
        items.push_back(mk(1'b1, 8'd0, 32'd0, 1'b0));

        for (int k = 0; k < 4; k++) pool[k] = 8'($urandom);
        n = 0;
        while (n < 100) begin
            case ($urandom_range(0, 9))
                0: items.push_back(mk(1'b1, 8'($urandom), $urandom,
                                      1'($urandom_range(0, 1))));
                1: begin
                    items.push_back(mk(1'b0, 8'($urandom), $urandom_range(0, 32'hffff_fffe),
                                       1'($urandom_range(0, 1))));
                end
                2, 3: begin
                    // contiguous write burst, sometimes across the wrap
                    base = $urandom_range(0, 1) ? 32'(32'hffff_fff0 + $urandom_range(0, 8))
                                                : 32'($urandom_range(0, 60));
                    blen = $urandom_range(3, 10);
                    for (int k = 0; k < blen; k++) begin
                        if (base + 32'(k) != bbcd_pkg::EMPTY_TAG)
                            items.push_back(mk(1'b0, pool[0], base + 32'(k), 1'b1));
                        n++;
                    end
                end
                default: items.push_back(mk(1'b0, pool[$urandom_range(0, 3)],
                                             32'($urandom_range(0, 70)),
                                             1'($urandom_range(0, 1))));
            endcase
            n++;
        end
        items.push_back(mk(1'b1, 8'd0, 32'd0, 1'b0));

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (items[k]) begin
            it = items[k];
            @(negedge clk);
            if (k > items.size() - 20) quiet = 1;
            if (!quiet && $urandom_range(0, 4) == 0) begin
                in_valid <= 1'b0;
                gap = $urandom_range(1, 12);
                repeat (gap) @(negedge clk);
            end
            typed_q.push_back(it);
            in_valid <= 1'b1;
            cmd <= it.cmd;
            dev <= it.dev;
            block <= it.blk;
            is_write <= it.wr;
            do @(posedge clk); while (in_stall);
        end
        @(negedge clk);
        in_valid <= 1'b0;

        while (pending_beats.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (fails == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end
endmodule
